FILE: rtl/core/lr_pkg.sv
// Shared types and constants for the line rasterizer.
`timescale 1ns / 1ps
package lr_pkg;

  localparam int ADDR_W     = 32;
  localparam int COLOUR_W   = 32;
  localparam int PITCH_W    = 13;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd1024;
  localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'd0;

  typedef enum logic [0:0] {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_BASE = 1'b0,
    CFG_LINE_PITCH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } walk_status_t;

endpackage

FILE: rtl/core/lr_addr.sv
// Framebuffer byte address: base + 4*pitch*y + 4*x, modulo 2^32.
`timescale 1ns / 1ps
module lr_addr #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]      pix_x,
  input  logic [COORD_BITS-1:0]      pix_y,
  input  logic [lr_pkg::PITCH_W-1:0] pitch,
  input  logic [lr_pkg::ADDR_W-1:0]  base,
  output logic [lr_pkg::ADDR_W-1:0]  addr
);
  import lr_pkg::*;

  localparam int PROD_W = PITCH_W + COORD_BITS;

  logic [PROD_W-1:0] row_off;
  logic [ADDR_W-1:0] row_bytes;
  logic [ADDR_W-1:0] col_bytes;

  assign row_off   = PROD_W'(pitch) * PROD_W'(pix_y);
  assign row_bytes = ADDR_W'(row_off) << 2;
  assign col_bytes = ADDR_W'(pix_x) << 2;
  assign addr      = base + row_bytes + col_bytes;

endmodule

FILE: rtl/core/lr_walk.sv
// Bresenham walk state and next-pixel logic.
`timescale 1ns / 1ps
module lr_walk #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic                        cmd,
  input  logic [COORD_BITS-1:0]       sx,
  input  logic [COORD_BITS-1:0]       sy,
  input  logic [COORD_BITS-1:0]       ex,
  input  logic [COORD_BITS-1:0]       ey,
  input  logic [lr_pkg::COLOUR_W-1:0] colour,
  output logic [COORD_BITS-1:0]       pix_x,
  output logic [COORD_BITS-1:0]       pix_y,
  output logic [lr_pkg::COLOUR_W-1:0] pix_colour,
  output lr_pkg::walk_status_t        status
);
  import lr_pkg::*;

  localparam int ERR_W = COORD_BITS + 2;

  logic [COORD_BITS-1:0]   cur_x_r, cur_y_r, stop_x_r, stop_y_r, delta_x_r, delta_y_r;
  logic                    step_x_neg_r, step_y_neg_r, active_r;
  logic signed [ERR_W-1:0] error_r;
  logic [COLOUR_W-1:0]     colour_r;

  logic [COORD_BITS-1:0]   cur_x_nxt, cur_y_nxt, stop_x_nxt, stop_y_nxt;
  logic [COORD_BITS-1:0]   delta_x_nxt, delta_y_nxt;
  logic                    step_x_neg_nxt, step_y_neg_nxt;
  logic signed [ERR_W-1:0] error_nxt;

  // start path
  logic                    swap;
  logic [COORD_BITS-1:0]   x0, y0, x1, y1, dx, dy;
  logic signed [ERR_W-1:0] half_dx, half_dy, err_init;

  // advance path
  logic signed [ERR_W-1:0] dx_e, dy_e, neg_dx, err_adv;
  logic                    move_x, move_y;
  logic [COORD_BITS-1:0]   adv_x, adv_y;

  logic is_start, take, last;

  assign is_start = (cmd == CMD_START);

  always_comb begin
    swap     = (sx > ex) || (sy > ey);
    x0       = swap ? ex : sx;
    y0       = swap ? ey : sy;
    x1       = swap ? sx : ex;
    y1       = swap ? sy : ey;
    dx       = (x0 < x1) ? (x1 - x0) : (x0 - x1);
    dy       = (y0 < y1) ? (y1 - y0) : (y0 - y1);
    half_dx  = $signed({2'b00, dx >> 1});
    half_dy  = $signed({2'b00, dy >> 1});
    err_init = (dx > dy) ? half_dx : -half_dy;
  end

  always_comb begin
    dx_e    = $signed({2'b00, delta_x_r});
    dy_e    = $signed({2'b00, delta_y_r});
    neg_dx  = -dx_e;
    move_x  = error_r > neg_dx;
    move_y  = error_r < dy_e;
    err_adv = error_r - (move_x ? dy_e : '0) + (move_y ? dx_e : '0);
    adv_x   = cur_x_r;
    adv_y   = cur_y_r;
    if (move_x) begin
      adv_x = step_x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    end
    if (move_y) begin
      adv_y = step_y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    end
  end

  always_comb begin
    if (is_start) begin
      cur_x_nxt      = x0;
      cur_y_nxt      = y0;
      stop_x_nxt     = x1;
      stop_y_nxt     = y1;
      delta_x_nxt    = dx;
      delta_y_nxt    = dy;
      step_x_neg_nxt = !(x0 < x1);
      step_y_neg_nxt = !(y0 < y1);
      error_nxt      = err_init;
    end else begin
      cur_x_nxt      = adv_x;
      cur_y_nxt      = adv_y;
      stop_x_nxt     = stop_x_r;
      stop_y_nxt     = stop_y_r;
      delta_x_nxt    = delta_x_r;
      delta_y_nxt    = delta_y_r;
      step_x_neg_nxt = step_x_neg_r;
      step_y_neg_nxt = step_y_neg_r;
      error_nxt      = err_adv;
    end
  end

  assign take  = fire && (is_start || active_r);
  assign last  = (cur_x_nxt == stop_x_nxt) && (cur_y_nxt == stop_y_nxt);

  assign pix_x        = cur_x_nxt;
  assign pix_y        = cur_y_nxt;
  assign pix_colour   = is_start ? colour : colour_r;
  assign status       = '{valid: take, last: last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      stop_x_r     <= '0;
      stop_y_r     <= '0;
      delta_x_r    <= '0;
      delta_y_r    <= '0;
      step_x_neg_r <= 1'b0;
      step_y_neg_r <= 1'b0;
      error_r      <= '0;
      colour_r     <= '0;
    end else if (take) begin
      active_r     <= !last;
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      stop_x_r     <= stop_x_nxt;
      stop_y_r     <= stop_y_nxt;
      delta_x_r    <= delta_x_nxt;
      delta_y_r    <= delta_y_nxt;
      step_x_neg_r <= step_x_neg_nxt;
      step_y_neg_r <= step_y_neg_nxt;
      error_r      <= error_nxt;
      colour_r     <= pix_colour;
    end
  end

endmodule

FILE: rtl/core/line_rasterizer_unit.sv
// Line rasterizer top level: input register, walk, address, result register.
//
//   channel  dir  handshake           payload
//   in_      in   in_valid/in_stall   command, endpoints, colour
//   out_     out  out_valid/out_stall pixel x/y, address, value, last flag
//   cfg_     in   cfg_write_en        cfg_index, cfg_data
//
// One beat per clock in and out unless stalled; a result passes the input register, then the result register.
// Rate is set by the walk update, computed combinationally from the error and position registers.
// Synchronous active-low reset empties both registers and clears the walk state.
// A stalled result holds in the output register; one more beat waits in the input register.
`timescale 1ns / 1ps
module line_rasterizer_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [COORD_BITS-1:0]         in_start_x,
  input  logic [COORD_BITS-1:0]         in_start_y,
  input  logic [COORD_BITS-1:0]         in_end_x,
  input  logic [COORD_BITS-1:0]         in_end_y,
  input  logic [lr_pkg::COLOUR_W-1:0]   in_colour,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COORD_BITS-1:0]         out_pixel_x,
  output logic [COORD_BITS-1:0]         out_pixel_y,
  output logic [lr_pkg::ADDR_W-1:0]     out_pixel_address,
  output logic [lr_pkg::COLOUR_W-1:0]   out_pixel_value,
  output logic                          out_last_pixel,
  input  logic                          cfg_write_en,
  input  logic [lr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lr_pkg::*;

  logic [ADDR_W-1:0]  frame_base_r;
  logic [PITCH_W-1:0] line_pitch_r;

  logic                  s1_valid_r, s1_cmd_r;
  logic [COORD_BITS-1:0] s1_sx_r, s1_sy_r, s1_ex_r, s1_ey_r;
  logic [COLOUR_W-1:0]   s1_colour_r;

  logic                  out_valid_r, out_last_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic [ADDR_W-1:0]     out_addr_r;
  logic [COLOUR_W-1:0]   out_value_r;

  logic                  out_free, s1_fire, in_take;
  logic [COORD_BITS-1:0] pix_x, pix_y;
  logic [COLOUR_W-1:0]   pix_colour;
  logic [ADDR_W-1:0]     pix_addr;
  walk_status_t          status;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= BASE_RESET;
      line_pitch_r <= PITCH_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_FRAME_BASE: frame_base_r <= cfg_data[ADDR_W-1:0];
        CFG_LINE_PITCH: line_pitch_r <= cfg_data[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r    <= in_command;
      s1_sx_r     <= in_start_x;
      s1_sy_r     <= in_start_y;
      s1_ex_r     <= in_end_x;
      s1_ey_r     <= in_end_y;
      s1_colour_r <= in_colour;
    end
  end

  lr_walk #(.COORD_BITS(COORD_BITS)) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s1_fire),
    .cmd        (s1_cmd_r),
    .sx         (s1_sx_r),
    .sy         (s1_sy_r),
    .ex         (s1_ex_r),
    .ey         (s1_ey_r),
    .colour     (s1_colour_r),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .pix_colour (pix_colour),
    .status     (status)
  );

  lr_addr #(.COORD_BITS(COORD_BITS)) u_addr (
    .pix_x (pix_x),
    .pix_y (pix_y),
    .pitch (line_pitch_r),
    .base  (frame_base_r),
    .addr  (pix_addr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= status.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (status.valid) begin
      out_x_r     <= pix_x;
      out_y_r     <= pix_y;
      out_addr_r  <= pix_addr;
      out_value_r <= pix_colour;
      out_last_r  <= status.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_x       = out_x_r;
  assign out_pixel_y       = out_y_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_value   = out_value_r;
  assign out_last_pixel    = out_last_r;

endmodule

FILE: rtl/core/lr_checker.sv
// Port-level assertions for the line rasterizer, bound to the top level.
`timescale 1ns / 1ps
module lr_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [COORD_BITS-1:0]         out_pixel_x,
  input logic [COORD_BITS-1:0]         out_pixel_y,
  input logic [lr_pkg::ADDR_W-1:0]     out_pixel_address,
  input logic [lr_pkg::COLOUR_W-1:0]   out_pixel_value,
  input logic                          out_last_pixel,
  input logic                          cfg_write_en,
  input logic [lr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [lr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lr_pkg::*;

  logic [ADDR_W-1:0]  base_r;
  logic [PITCH_W-1:0] pitch_r;
  logic [ADDR_W-1:0]  exp_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_RESET;
      pitch_r <= PITCH_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_FRAME_BASE: base_r  <= cfg_data[ADDR_W-1:0];
        CFG_LINE_PITCH: pitch_r <= cfg_data[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  assign exp_addr = base_r + ((ADDR_W'(pitch_r) * ADDR_W'(out_pixel_y)) << 2)
                  + (ADDR_W'(out_pixel_x) << 2);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y)
      && $stable(out_pixel_address) && $stable(out_pixel_value) && $stable(out_last_pixel))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel_address == exp_addr)
    else $error("pixel address mismatch");

endmodule

bind line_rasterizer_unit lr_checker #(.COORD_BITS(COORD_BITS)) u_lr_checker (.*);
